// File: rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_CALL = 1'b1;

    localparam int NUM_BASES = 4;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [12:0] window_start;
        logic [12:0] window_end;
        logic [11:0] read_start;
        logic [12:0] read_length;
        logic [11:0] base_offset;
        logic [2:0]  base_code;
        logic [11:0] query_position;
    } t_in_word;

    typedef struct packed {
        logic [11:0] call_position;
        logic        covered;
        logic [1:0]  base_call;
    } t_out_word;

    // decoded operation carried from the read stage to the update stage
    typedef struct packed {
        logic        is_call;
        logic        hit;
        logic [1:0]  code;
        logic [11:0] qpos;
    } t_op;

endpackage

`default_nettype wire

// File: rtl/bpc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
    import bpc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpc_out_if;
    import bpc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bpc_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bpc_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_decode #(
    parameter int POSITIONS = 4096,
    parameter int AW        = 12
) (
    input  wire bpc_pkg::t_in_word i_word,
    output bpc_pkg::t_op           o_op,
    output logic [AW-1:0]          o_addr
);
    import bpc_pkg::*;

    logic [12:0] pos;
    logic [13:0] read_end;
    logic        window_ok;
    logic        add_ok;
    logic        query_ok;

    always_comb begin
        pos       = {1'b0, i_word.read_start} + {1'b0, i_word.base_offset};
        read_end  = {2'b0, i_word.read_start} + {1'b0, i_word.read_length};
        window_ok = ({1'b0, i_word.read_start} >= i_word.window_start)
                    && (read_end <= {1'b0, i_word.window_end});
        add_ok    = window_ok
                    && ({1'b0, i_word.base_offset} < i_word.read_length)
                    && !i_word.base_code[2]
                    && (32'(pos) < 32'(POSITIONS));
        query_ok  = 32'(i_word.query_position) < 32'(POSITIONS);

        o_op.is_call = (i_word.cmd == CMD_CALL);
        o_op.hit     = o_op.is_call ? query_ok : add_ok;
        o_op.code    = i_word.base_code[1:0];
        o_op.qpos    = i_word.query_position;
        o_addr       = o_op.is_call ? AW'(i_word.query_position) : AW'(pos);
    end

endmodule

`default_nettype wire

// File: rtl/bpc_update.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_update #(
    parameter int CW = 16
) (
    input  wire bpc_pkg::t_op               i_op,
    input  wire logic [4*CW-1:0]            i_entry,
    output logic      [4*CW-1:0]            o_wr_data,
    output bpc_pkg::t_out_word              o_result
);
    import bpc_pkg::*;

    logic [CW-1:0] cnt;
    logic [CW-1:0] best;
    logic [1:0]    best_code;
    logic          cov;
    logic [CW-1:0] sel;
    logic [CW-1:0] inc;

    // strictly greater keeps the lower code on ties
    always_comb begin
        best      = '0;
        best_code = BASE_A;
        cov       = 1'b0;
        cnt       = '0;
        for (int j = 0; j < NUM_BASES; j++) begin
            cnt = i_entry[j*CW +: CW];
            if (cnt > best) begin
                best      = cnt;
                best_code = 2'(j);
                cov       = 1'b1;
            end
        end
    end

    always_comb begin
        sel = i_entry[i_op.code*CW +: CW];
        inc = (sel == '1) ? sel : sel + CW'(1);
        o_wr_data = i_entry;
        if (i_op.is_call) begin
            o_wr_data = '0;
        end else begin
            o_wr_data[i_op.code*CW +: CW] = inc;
        end
        o_result.call_position = i_op.qpos;
        o_result.covered       = i_op.hit & cov;
        o_result.base_call     = i_op.hit ? best_code : BASE_A;
    end

endmodule

`default_nettype wire

// File: rtl/base_pileup_consensus_top.sv
// Base pileup with majority consensus call.
// Input channel i_in takes one command word: add one read base to the pileup
// (no result word) or call the consensus at a position and clear it (one
// result word on o_out). Bases outside the window, beyond their read, with an
// unknown code or beyond the store are dropped; counts saturate.
// Words are taken one per cycle. Each word reads its pileup entry in the
// cycle it is accepted and writes it back once the update stage completes;
// a back-to-back word to the same entry gets the written value forwarded.
// A call result passes from the update stage into an output register, where
// it is held until taken. While that register is full and not
// drained, a second call waits in the update stage and i_in.ready drops;
// an add behind it waits too.
// After reset the block walks the store clearing one entry per cycle;
// i_in.ready stays low until that pass is done.
`timescale 1ns / 1ps
`default_nettype none

module base_pileup_consensus_top #(
    parameter int POSITIONS   = 4096,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bpc_in_if.sink    i_in,
    bpc_out_if.source o_out
);
    import bpc_pkg::*;

    localparam int AW = $clog2(POSITIONS);
    localparam int DW = 4 * COUNT_WIDTH;

    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    logic          r_s1_valid;
    t_op           r_s1_op;
    logic [AW-1:0] r_s1_addr;
    logic          r_fwd;
    logic [DW-1:0] r_fwd_data;

    logic          r_out_valid;
    t_out_word     r_out_data;

    t_op           dec_op;
    logic [AW-1:0] dec_addr;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] s1_entry;
    logic [DW-1:0] upd_wdata;
    t_out_word     upd_result;

    logic          s1_done;
    logic          in_ready;
    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    bpc_decode #(
        .POSITIONS (POSITIONS),
        .AW        (AW)
    ) u_decode (
        .i_word (i_in.data),
        .o_op   (dec_op),
        .o_addr (dec_addr)
    );

    bpc_mem #(
        .DEPTH (POSITIONS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (dec_addr),
        .o_rd_data (rd_data)
    );

    bpc_update #(
        .CW (COUNT_WIDTH)
    ) u_update (
        .i_op      (r_s1_op),
        .i_entry   (s1_entry),
        .o_wr_data (upd_wdata),
        .o_result  (upd_result)
    );

    always_comb begin
        s1_entry = r_fwd ? r_fwd_data : rd_data;
        s1_done  = r_s1_valid && (!r_s1_op.is_call || !r_out_valid || o_out.ready);
        in_ready = !r_clr && (!r_s1_valid || s1_done);
        accept   = i_in.valid && in_ready;
        wr_en    = r_clr || (s1_done && r_s1_op.hit);
        wr_addr  = r_clr ? r_clr_addr : r_s1_addr;
        wr_data  = r_clr ? '0 : upd_wdata;
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (r_clr_addr == AW'(POSITIONS - 1)) begin
                r_clr <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_fwd      <= s1_done && r_s1_op.hit && (r_s1_addr == dec_addr);
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= dec_op;
            r_s1_addr  <= dec_addr;
            r_fwd_data <= upd_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_done && r_s1_op.is_call) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && r_s1_op.is_call) begin
            r_out_data <= upd_result;
        end
    end

    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !r_s1_valid)
        else $error("update stage busy during clearing pass");

    a_clr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> (wr_en && wr_data == '0))
        else $error("clearing pass wrote nonzero entry");

    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s1_done && r_s1_op.hit && wr_addr == dec_addr) |=> r_fwd)
        else $error("same-entry write not forwarded");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_op.is_call))
        else $error("result word without a call");

endmodule

`default_nettype wire
